// File: src/smpwm_pkg.sv
`timescale 1ns / 1ps

package smpwm_pkg;

    localparam int CHANNELS  = 8;
    localparam int LEN_W     = 16;
    localparam int CHAN_W    = 3;
    localparam int PIN_W     = 8;
    localparam int CFG_IDX_W = 1;
    // slot counter also holds CHANNELS itself (the idle part of the cycle)
    localparam int SLOT_W    = $clog2(CHANNELS + 1);
    localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam logic [LEN_W-1:0] CYCLE_LENGTH_RST = LEN_W'(20000);
    localparam logic [LEN_W-1:0] SLOT_LENGTH_RST  = LEN_W'(2500);
    localparam logic [LEN_W-1:0] LEN_MAX          = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CYCLE_LENGTH = 1'b0,
        CFG_SLOT_LENGTH  = 1'b1
    } cfg_idx_t;

    typedef enum logic {
        KIND_TICK = 1'b0,
        KIND_MARK = 1'b1
    } kind_t;

    typedef struct packed {
        logic [LEN_W-1:0] cycle_length;
        logic [LEN_W-1:0] slot_length;
    } pwm_cfg_t;

    // a length written as zero behaves as one
    function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] v);
        return (v == '0) ? LEN_W'(1) : v;
    endfunction

endpackage

// File: src/smpwm_sched.sv
`timescale 1ns / 1ps

module smpwm_sched
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           tick,
    input  smpwm_pkg::pwm_cfg_t            cfg,
    input  logic [smpwm_pkg::LEN_W-1:0]    mark_rd,
    output logic [smpwm_pkg::CH_IDX_W-1:0] slot_idx,
    output logic [smpwm_pkg::CHANNELS-1:0] levels
);
    import smpwm_pkg::*;

    logic [SLOT_W-1:0] slot_number_reg, slot_number_next;
    logic [LEN_W-1:0]  slot_time_reg, slot_time_next;
    logic [LEN_W-1:0]  cycle_time_reg, cycle_time_next;
    logic [LEN_W-1:0]  held_mark_reg, held_mark_next;

    logic [LEN_W-1:0]  slen;
    logic [LEN_W-1:0]  clen;
    logic              in_slot;
    logic [LEN_W-1:0]  sampled;
    logic [LEN_W:0]    slot_time_inc;
    logic              slot_done;

    assign slot_idx = CH_IDX_W'(slot_number_reg);

    always_comb
    begin
        slen    = eff_len(cfg.slot_length);
        clen    = eff_len(cfg.cycle_length);
        in_slot = (slot_number_reg < SLOT_W'(CHANNELS));

        // mark is sampled on the first tick of a slot, clipped to the slot
        if (in_slot && (slot_time_reg == '0))
        begin
            sampled = (mark_rd > slen) ? slen : mark_rd;
        end
        else
        begin
            sampled = held_mark_reg;
        end

        if (in_slot && (slot_time_reg < sampled))
        begin
            levels = CHANNELS'(1) << slot_idx;
        end
        else
        begin
            levels = '0;
        end

        slot_time_inc = {1'b0, slot_time_reg} + (LEN_W+1)'(1);
        slot_done     = (slot_time_inc >= {1'b0, slen});

        slot_number_next = slot_number_reg;
        slot_time_next   = slot_time_reg;
        held_mark_next   = held_mark_reg;
        cycle_time_next  = (cycle_time_reg == LEN_MAX) ? cycle_time_reg
                                                        : cycle_time_reg + LEN_W'(1);

        if (in_slot)
        begin
            if (slot_done)
            begin
                slot_time_next   = '0;
                held_mark_next   = '0;
                slot_number_next = slot_number_reg + SLOT_W'(1);
            end
            else
            begin
                slot_time_next = slot_time_inc[LEN_W-1:0];
                held_mark_next = sampled;
            end
        end

        if ((slot_number_next >= SLOT_W'(CHANNELS)) && (cycle_time_next >= clen))
        begin
            slot_number_next = '0;
            slot_time_next   = '0;
            cycle_time_next  = '0;
            held_mark_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_number_reg <= '0;
            slot_time_reg   <= '0;
            cycle_time_reg  <= '0;
            held_mark_reg   <= '0;
        end
        else if (tick)
        begin
            slot_number_reg <= slot_number_next;
            slot_time_reg   <= slot_time_next;
            cycle_time_reg  <= cycle_time_next;
            held_mark_reg   <= held_mark_next;
        end
    end

endmodule

// File: src/slotted_multichannel_pwm_unit.sv
`timescale 1ns / 1ps
// Channel  Handshake              Payload
// in       in_valid / in_ready    kind, channel, mark_value
// out      out_valid / out_ready  pin_levels
// cfg      cfg_wr_en              cfg_index, cfg_data
//
// One beat in per clock while in_ready is high; its result sits in the output register in the next cycle.
// Throughput is set by the single output register: in_ready drops only while
// a result waits and out_ready is low, so a stalled sink holds the input side.
// Reset clears the mark store, the slot counters and the last pin levels at once.

module slotted_multichannel_pwm_unit
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             kind,
    input  logic [smpwm_pkg::CHAN_W-1:0]     channel,
    input  logic [smpwm_pkg::LEN_W-1:0]      mark_value,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [smpwm_pkg::PIN_W-1:0]      pin_levels,
    input  logic                             cfg_wr_en,
    input  logic [smpwm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [smpwm_pkg::LEN_W-1:0]      cfg_data
);
    import smpwm_pkg::*;

    pwm_cfg_t            cfg_reg;
    logic [LEN_W-1:0]    mark_store_reg [CHANNELS];
    logic [PIN_W-1:0]    last_levels_reg;
    logic [PIN_W-1:0]    pin_levels_reg, pin_levels_next;
    logic                out_valid_reg;

    logic                in_beat;
    logic                tick;
    logic                mark_wr;
    logic [CH_IDX_W-1:0] slot_idx;
    logic [CHANNELS-1:0] levels;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_beat   = in_valid && in_ready;
    assign tick      = in_beat && (kind_t'(kind) == KIND_TICK);
    assign mark_wr   = in_beat && (kind_t'(kind) == KIND_MARK)
                       && (32'(channel) < CHANNELS);
    assign out_valid  = out_valid_reg;
    assign pin_levels = pin_levels_reg;

    smpwm_sched u_sched
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .tick     (tick),
        .cfg      (cfg_reg),
        .mark_rd  (mark_store_reg[slot_idx]),
        .slot_idx (slot_idx),
        .levels   (levels)
    );

    // a mark write repeats the levels of the last tick
    assign pin_levels_next = (kind_t'(kind) == KIND_TICK) ? PIN_W'(levels) : last_levels_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cycle_length <= CYCLE_LENGTH_RST;
            cfg_reg.slot_length  <= SLOT_LENGTH_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_CYCLE_LENGTH: cfg_reg.cycle_length <= cfg_data;
                CFG_SLOT_LENGTH:  cfg_reg.slot_length  <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                mark_store_reg[i] <= '0;
            end
        end
        else if (mark_wr)
        begin
            mark_store_reg[CH_IDX_W'(channel)] <= mark_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            last_levels_reg <= '0;
        end
        else
        begin
            if (in_beat)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (tick)
            begin
                last_levels_reg <= PIN_W'(levels);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            pin_levels_reg <= pin_levels_next;
        end
    end

endmodule

// File: src/smpwm_chk.sv
`timescale 1ns / 1ps

module smpwm_chk
(
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [smpwm_pkg::PIN_W-1:0]      pin_levels
);
    import smpwm_pkg::*;

    // at most one channel is high in any slot
    a_onehot_levels: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot0(pin_levels))
        else $error("more than one pin high");

    // every accepted beat yields a result in the next cycle
    a_beat_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> out_valid)
        else $error("accepted beat produced no result");

    // input is held off only while a result waits
    a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid || out_ready) |-> in_ready)
        else $error("input stalled with output free");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(pin_levels)))
        else $error("stalled result changed");

endmodule

bind slotted_multichannel_pwm_unit smpwm_chk u_smpwm_chk (.*);
